### rtl/core/token_bucket_throttle_defines.svh
// Assertion macros shared by the token bucket throttle RTL.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef TOKEN_BUCKET_THROTTLE_DEFINES_SVH
`define TOKEN_BUCKET_THROTTLE_DEFINES_SVH

// checked only out of reset
`define TBT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TBT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/tbt_pkg.sv
// Types and constants for the token bucket throttle.
// No dependencies; used by every module of the block.
package tbt_pkg;

   localparam int LEN_BITS      = 20;
   localparam int CNT_BITS      = 10;
   localparam int MAX_TRANSFERS = 1023;
   localparam int HOUR_BITS     = 5;
   localparam int LIM_BITS      = 16;
   localparam int KIB_SHIFT     = 10;
   localparam int DVD_BITS      = LIM_BITS + KIB_SHIFT;
   localparam int TOK_BITS      = 27;
   localparam int DIV_CNT_BITS  = $clog2(DVD_BITS);
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;
   localparam int Q_DEPTH       = 2;
   localparam int Q_PTR_BITS    = 1;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_THROTTLE_EN = 4'd0,
      CSR_WINDOW_EN   = 4'd1,
      CSR_START_HOUR  = 4'd2,
      CSR_END_HOUR    = 4'd3,
      CSR_DOWN_MAIN   = 4'd4,
      CSR_DOWN_ALT    = 4'd5,
      CSR_UP_MAIN     = 4'd6,
      CSR_UP_ALT      = 4'd7
   } csr_idx_type;

   // one classified request between front and back
   // len carries bytes_read for a read-done request
   // tick: lim_a = down limit, lim_b = up limit (zero when disabled)
   // read/write: lim_a = limit of that direction
   typedef struct packed {
      kind_type              kind;
      logic [LEN_BITS-1:0]   len;
      logic [CNT_BITS-1:0]   count;
      logic [LIM_BITS-1:0]   lim_a;
      logic [LIM_BITS-1:0]   lim_b;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

### rtl/core/token_bucket_throttle.sv
// Channel   | Direction | Handshake       | Carries
// req_*     | in        | valid / stall   | kind, request_len, transfer_count, hour, bytes_read
// rsp_*     | out       | valid / stall   | grant_len, passthrough, must_wait
// csr_*     | in        | valid / ready   | register index, write data
// Tick and read-done requests are handled in the back end's idle state; a read or write
// that reaches the bucket math goes through the bit-serial slice divider (one quotient
// bit per cycle over 26 dividend bits) and then a finish state that registers the result.
// A two-entry queue lets the front keep accepting while the back works.
// reset is synchronous, active high; csr_ready is always high.
// rsp_stall holds the result register and backs up the queue to req_stall.
module token_bucket_throttle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [tbt_pkg::LEN_BITS-1:0]        req_request_len,
   input  logic [tbt_pkg::CNT_BITS-1:0]        req_transfer_count,
   input  logic [tbt_pkg::HOUR_BITS-1:0]       req_current_hour,
   input  logic [tbt_pkg::LEN_BITS-1:0]        req_bytes_read,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbt_pkg::LEN_BITS-1:0]        rsp_grant_len,
   output logic                                rsp_passthrough,
   output logic                                rsp_must_wait,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tbt_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   tbt_pkg::q_ctl_type   q_ctl;
   tbt_pkg::q_stat_type  q_stat;
   tbt_pkg::entry_type   wr_entry, rd_entry;
   logic                 push, pop;

   assign q_ctl.push = push;
   assign q_ctl.pop  = pop;

   tbt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_request_len    (req_request_len),
      .req_transfer_count (req_transfer_count),
      .req_current_hour   (req_current_hour),
      .req_bytes_read     (req_bytes_read),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .q_full             (q_stat.full),
      .q_push             (push),
      .q_entry            (wr_entry)
   );

   tbt_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry),
      .stat     (q_stat)
   );

   tbt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (rd_entry),
      .q_empty         (q_stat.empty),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_grant_len   (rsp_grant_len),
      .rsp_passthrough (rsp_passthrough),
      .rsp_must_wait   (rsp_must_wait)
   );

endmodule

### rtl/core/tbt_front.sv
// Front end: config registers, request accept, window and limit selection.
// Depends on tbt_pkg.
module tbt_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [tbt_pkg::LEN_BITS-1:0]        req_request_len,
   input  logic [tbt_pkg::CNT_BITS-1:0]        req_transfer_count,
   input  logic [tbt_pkg::HOUR_BITS-1:0]       req_current_hour,
   input  logic [tbt_pkg::LEN_BITS-1:0]        req_bytes_read,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbt_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tbt_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                q_full,
   output logic                                q_push,
   output tbt_pkg::entry_type                  q_entry
);

   logic                              thr_en_ff, thr_en_in;
   logic                              win_en_ff, win_en_in;
   logic [tbt_pkg::HOUR_BITS-1:0]     start_ff, start_in;
   logic [tbt_pkg::HOUR_BITS-1:0]     end_ff, end_in;
   logic [tbt_pkg::LIM_BITS-1:0]      dmain_ff, dmain_in, dalt_ff, dalt_in;
   logic [tbt_pkg::LIM_BITS-1:0]      umain_ff, umain_in, ualt_ff, ualt_in;
   logic                              in_win;
   logic [tbt_pkg::LIM_BITS-1:0]      down_lim, up_lim;
   logic [tbt_pkg::CNT_BITS-1:0]      count_sat;
   tbt_pkg::kind_type                 kind;

   assign csr_ready = 1'b1;

   always_comb begin
      thr_en_in = thr_en_ff;
      win_en_in = win_en_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      dmain_in  = dmain_ff;
      dalt_in   = dalt_ff;
      umain_in  = umain_ff;
      ualt_in   = ualt_ff;
      if (csr_valid) begin
         case (tbt_pkg::csr_idx_type'(csr_index))
            tbt_pkg::CSR_THROTTLE_EN: thr_en_in = csr_data[0];
            tbt_pkg::CSR_WINDOW_EN:   win_en_in = csr_data[0];
            tbt_pkg::CSR_START_HOUR:  start_in  = csr_data[tbt_pkg::HOUR_BITS-1:0];
            tbt_pkg::CSR_END_HOUR:    end_in    = csr_data[tbt_pkg::HOUR_BITS-1:0];
            tbt_pkg::CSR_DOWN_MAIN:   dmain_in  = csr_data[tbt_pkg::LIM_BITS-1:0];
            tbt_pkg::CSR_DOWN_ALT:    dalt_in   = csr_data[tbt_pkg::LIM_BITS-1:0];
            tbt_pkg::CSR_UP_MAIN:     umain_in  = csr_data[tbt_pkg::LIM_BITS-1:0];
            tbt_pkg::CSR_UP_ALT:      ualt_in   = csr_data[tbt_pkg::LIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_en_ff <= 1'b0;
         win_en_ff <= 1'b0;
         start_ff  <= '0;
         end_ff    <= '0;
         dmain_ff  <= '0;
         dalt_ff   <= '0;
         umain_ff  <= '0;
         ualt_ff   <= '0;
      end else begin
         thr_en_ff <= thr_en_in;
         win_en_ff <= win_en_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         dmain_ff  <= dmain_in;
         dalt_ff   <= dalt_in;
         umain_ff  <= umain_in;
         ualt_ff   <= ualt_in;
      end
   end

   // window may wrap past midnight; equal bounds mean never inside
   always_comb begin
      in_win = 1'b0;
      if (win_en_ff) begin
         if (start_ff < end_ff)
            in_win = (req_current_hour >= start_ff) && (req_current_hour < end_ff);
         else if (start_ff > end_ff)
            in_win = (req_current_hour >= start_ff) || (req_current_hour < end_ff);
      end
   end

   assign down_lim  = in_win ? dalt_ff : dmain_ff;
   assign up_lim    = in_win ? ualt_ff : umain_ff;
   assign count_sat = (int'(req_transfer_count) > tbt_pkg::MAX_TRANSFERS) ?
                      tbt_pkg::CNT_BITS'(tbt_pkg::MAX_TRANSFERS) : req_transfer_count;
   assign kind      = tbt_pkg::kind_type'(req_kind);

   always_comb begin
      q_entry.kind  = kind;
      q_entry.len   = req_request_len;
      q_entry.count = count_sat;
      q_entry.lim_a = down_lim;
      q_entry.lim_b = up_lim;
      case (kind)
         tbt_pkg::KIND_TICK: begin
            if (!thr_en_ff) begin
               q_entry.lim_a = '0;
               q_entry.lim_b = '0;
            end
         end
         tbt_pkg::KIND_WRITE: q_entry.lim_a = up_lim;
         tbt_pkg::KIND_DONE:  q_entry.len   = req_bytes_read;
         default: ;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

### rtl/core/tbt_fifo.sv
// Two-entry queue between front and back of the throttle.
// Depends on tbt_pkg.
module tbt_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  tbt_pkg::q_ctl_type    ctl,
   input  tbt_pkg::entry_type    wr_entry,
   output tbt_pkg::entry_type    rd_entry,
   output tbt_pkg::q_stat_type   stat
);

   tbt_pkg::entry_type                  mem_ff [tbt_pkg::Q_DEPTH];
   logic [tbt_pkg::Q_PTR_BITS-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [tbt_pkg::Q_PTR_BITS:0]        cnt_ff, cnt_in;

   assign stat.full  = (int'(cnt_ff) == tbt_pkg::Q_DEPTH);
   assign stat.empty = (cnt_ff == '0);
   assign rd_entry   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = ctl.push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = ctl.pop  ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (ctl.push && !ctl.pop)
         cnt_in = cnt_ff + 1'b1;
      else if (!ctl.push && ctl.pop)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (ctl.push)
         mem_ff[wp_ff] <= wr_entry;
   end

endmodule

### rtl/core/tbt_back.sv
// Back end: bucket state, serial slice divider and registered result.
// Depends on tbt_pkg and token_bucket_throttle_defines.svh.
`include "token_bucket_throttle_defines.svh"

module tbt_back (
   input  logic                            clock,
   input  logic                            reset,
   input  tbt_pkg::entry_type              q_head,
   input  logic                            q_empty,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tbt_pkg::LEN_BITS-1:0]    rsp_grant_len,
   output logic                            rsp_passthrough,
   output logic                            rsp_must_wait
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIN
   } state_type;

   state_type                              state_ff, state_in;
   logic                                   active_ff, active_in;
   logic                                   dunl_ff, dunl_in, uunl_ff, uunl_in;
   logic [tbt_pkg::TOK_BITS-1:0]           dtok_ff, dtok_in, utok_ff, utok_in;
   logic [tbt_pkg::DVD_BITS-1:0]           dvd_ff, dvd_in;
   logic [tbt_pkg::CNT_BITS-1:0]           dvs_ff, dvs_in, rem_ff, rem_in;
   logic [tbt_pkg::DIV_CNT_BITS-1:0]       step_ff, step_in;
   logic [tbt_pkg::LEN_BITS-1:0]           len_ff, len_in;
   logic                                   wr_ff, wr_in;
   logic                                   vld_ff, vld_in;
   logic [tbt_pkg::LEN_BITS-1:0]           grant_ff, grant_in;
   logic                                   pass_ff, pass_in, wait_ff, wait_in;

   logic                                   out_free, sel_unl, is_wr;
   logic [tbt_pkg::TOK_BITS-1:0]           sel_tok, got_ext, m1, m2;
   logic [tbt_pkg::CNT_BITS:0]             trial;

   assign out_free  = !vld_ff || !rsp_stall;
   assign is_wr     = (q_head.kind == tbt_pkg::KIND_WRITE);
   assign sel_unl   = is_wr ? uunl_ff : dunl_ff;
   assign sel_tok   = is_wr ? utok_ff : dtok_ff;
   assign got_ext   = tbt_pkg::TOK_BITS'(q_head.len);
   assign trial     = {rem_ff, dvd_ff[tbt_pkg::DVD_BITS-1]};

   // min(slice, len, tokens); len bounds the result to LEN_BITS
   assign m1 = (tbt_pkg::TOK_BITS'(dvd_ff) < tbt_pkg::TOK_BITS'(len_ff)) ?
               tbt_pkg::TOK_BITS'(dvd_ff) : tbt_pkg::TOK_BITS'(len_ff);
   assign m2 = (m1 < (wr_ff ? utok_ff : dtok_ff)) ? m1 : (wr_ff ? utok_ff : dtok_ff);

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      dunl_in   = dunl_ff;
      uunl_in   = uunl_ff;
      dtok_in   = dtok_ff;
      utok_in   = utok_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      len_in    = len_ff;
      wr_in     = wr_ff;
      vld_in    = vld_ff && rsp_stall;
      grant_in  = grant_ff;
      pass_in   = pass_ff;
      wait_in   = wait_ff;
      q_pop     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  tbt_pkg::KIND_TICK: begin
                     active_in = 1'b1;
                     dunl_in   = (q_head.lim_a == '0);
                     uunl_in   = (q_head.lim_b == '0);
                     dtok_in   = tbt_pkg::TOK_BITS'({q_head.lim_a,
                                 {tbt_pkg::KIB_SHIFT{1'b0}}});
                     utok_in   = tbt_pkg::TOK_BITS'({q_head.lim_b,
                                 {tbt_pkg::KIB_SHIFT{1'b0}}});
                  end
                  tbt_pkg::KIND_DONE: begin
                     if (active_ff && !dunl_ff)
                        dtok_in = (got_ext >= dtok_ff) ? '0 : dtok_ff - got_ext;
                  end
                  default: begin
                     if (!active_ff || sel_unl || q_head.count == '0) begin
                        vld_in   = 1'b1;
                        grant_in = q_head.len;
                        pass_in  = 1'b1;
                        wait_in  = 1'b0;
                     end else if (sel_tok == '0) begin
                        vld_in   = 1'b1;
                        grant_in = '0;
                        pass_in  = 1'b0;
                        wait_in  = 1'b1;
                     end else begin
                        dvd_in   = {q_head.lim_a, {tbt_pkg::KIB_SHIFT{1'b0}}};
                        dvs_in   = q_head.count;
                        rem_in   = '0;
                        step_in  = '0;
                        len_in   = q_head.len;
                        wr_in    = is_wr;
                        state_in = S_DIV;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = tbt_pkg::CNT_BITS'(trial - {1'b0, dvs_ff});
               dvd_in = {dvd_ff[tbt_pkg::DVD_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[tbt_pkg::CNT_BITS-1:0];
               dvd_in = {dvd_ff[tbt_pkg::DVD_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (int'(step_ff) == tbt_pkg::DVD_BITS - 1)
               state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               vld_in   = 1'b1;
               grant_in = m2[tbt_pkg::LEN_BITS-1:0];
               pass_in  = 1'b0;
               wait_in  = 1'b0;
               if (wr_ff)
                  utok_in = utok_ff - m2;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= 1'b0;
         dunl_ff   <= 1'b1;
         uunl_ff   <= 1'b1;
         dtok_ff   <= '0;
         utok_ff   <= '0;
         step_ff   <= '0;
         vld_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         dunl_ff   <= dunl_in;
         uunl_ff   <= uunl_in;
         dtok_ff   <= dtok_in;
         utok_ff   <= utok_in;
         step_ff   <= step_in;
         vld_ff    <= vld_in;
      end
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
      len_ff   <= len_in;
      wr_ff    <= wr_in;
      grant_ff <= grant_in;
      pass_ff  <= pass_in;
      wait_ff  <= wait_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_grant_len   = grant_ff;
   assign rsp_passthrough = pass_ff;
   assign rsp_must_wait   = wait_ff;

   `TBT_ASSERT(a_pop_only_idle, q_pop |-> (state_ff == S_IDLE), "pop outside idle")
   `TBT_ASSERT(a_wait_zero, (vld_ff && wait_ff) |-> (grant_ff == '0 && !pass_ff),
      "wait result with a grant")
   `TBT_ASSERT(a_div_enters_fin,
      (state_ff == S_DIV && int'(step_ff) == tbt_pkg::DVD_BITS - 1) |=> (state_ff == S_FIN),
      "divider did not finish")
   `TBT_ASSERT(a_div_divisor, (state_ff == S_DIV) |-> (dvs_ff != '0), "divide by zero")

endmodule
